/* rtl/hex_record_parser_unit_assert.svh */
// ----------------------------------------------------------------------------
// Hex record parser assertion macros
// Concurrent assertion shorthands used by the parser record core.
// ----------------------------------------------------------------------------
`ifndef HEX_RECORD_PARSER_UNIT_ASSERT_SVH
`define HEX_RECORD_PARSER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define HRP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hex record parser assertion failed");
`define HRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hex record parser assertion failed");
`else
`define HRP_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define HRP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/hrp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex record parser package
// Shared result codes, record types, widths and inter-module structs.
// ----------------------------------------------------------------------------
package hrp_pkg;

   localparam int unsigned ADDR_W = 34;

   localparam logic [2:0] KIND_DATA     = 3'd0;
   localparam logic [2:0] KIND_REC_OK   = 3'd1;
   localparam logic [2:0] KIND_END      = 3'd2;
   localparam logic [2:0] KIND_BASE     = 3'd3;
   localparam logic [2:0] KIND_DISCARD  = 3'd4;
   localparam logic [2:0] KIND_CSUM_ERR = 3'd5;
   localparam logic [2:0] KIND_FMT_ERR  = 3'd6;

   localparam logic [7:0] TYPE_DATA   = 8'h00;
   localparam logic [7:0] TYPE_EOF    = 8'h01;
   localparam logic [7:0] TYPE_SEG    = 8'h02;
   localparam logic [7:0] TYPE_LIN    = 8'h04;
   localparam logic [7:0] TYPE_DATA32 = 8'h20;

   localparam logic [9:0] DIGIT_MAX = 10'd1023;

   typedef struct packed {
      logic       is_eol;
      logic       is_colon;
      logic       is_hex;
      logic       is_blank;
      logic [3:0] hex_val;
   } char_class_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic [ADDR_W-1:0] byte_address;
      logic [7:0]        data_byte;
      logic              end_seen;
   } result_type;

endpackage

/* rtl/hrp_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex record parser character channel
// Valid/ready channel carrying one text character per beat.
// ----------------------------------------------------------------------------
interface hrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink (input valid, input char_in, output ready);
endinterface

/* rtl/hrp_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex record parser result channel
// Valid/ready channel carrying one parse result per beat.
// ----------------------------------------------------------------------------
interface hrp_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [2:0]                kind;
   logic [hrp_pkg::ADDR_W-1:0] byte_address;
   logic [7:0]                data_byte;
   logic                      end_seen;

   modport source (output valid, output kind, output byte_address, output data_byte,
                   output end_seen, input ready);
   modport sink (input valid, input kind, input byte_address, input data_byte,
                 input end_seen, output ready);
endinterface

/* rtl/hrp_char_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex record parser character stage
// Input register that accepts a character beat and stores its decoded class.
// ----------------------------------------------------------------------------
module hrp_char_stage (
   input  logic                    clock,
   input  logic                    reset,
   hrp_req_if.sink                 req,
   input  logic                    take,
   output logic                    cls_valid,
   output hrp_pkg::char_class_type cls
);

   logic                    valid_ff, valid_in;
   hrp_pkg::char_class_type cls_ff, cls_in;
   logic [7:0]              c;

   assign req.ready = !valid_ff || take;
   assign cls_valid = valid_ff;
   assign cls       = cls_ff;
   assign c         = req.char_in;

   always_comb begin
      cls_in          = '0;
      cls_in.is_eol   = (c == 8'h0D) || (c == 8'h0A);
      cls_in.is_colon = (c == 8'h3A);
      cls_in.is_blank = (c <= 8'h20);
      if (c >= 8'h30 && c <= 8'h39) begin
         cls_in.is_hex  = 1'b1;
         cls_in.hex_val = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         cls_in.is_hex  = 1'b1;
         cls_in.hex_val = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         cls_in.is_hex  = 1'b1;
         cls_in.hex_val = 4'(c - 8'h57);
      end
   end

   assign valid_in = (req.valid && req.ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         cls_ff <= cls_in;
      end
   end

endmodule

/* rtl/hrp_record_core.sv */
`timescale 1ns / 1ps
`include "hex_record_parser_unit_assert.svh"
// ----------------------------------------------------------------------------
// Hex record parser record core
// Record state machine, checksum, base registers and result formation.
// ----------------------------------------------------------------------------
module hrp_record_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic                    csr_wr_data,
   input  logic                    cls_valid,
   input  hrp_pkg::char_class_type cls,
   input  logic                    slot_free,
   output logic                    take,
   output logic                    res_load,
   output hrp_pkg::result_type     res
);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_SKIP  = 2'd1;
   localparam logic [1:0] PH_REC   = 2'd2;
   localparam logic [1:0] PH_TRAIL = 2'd3;

   logic [1:0]                 phase_ff, phase_in;
   logic [9:0]                 dc_ff, dc_in;
   logic [3:0]                 nib_ff, nib_in;
   logic [7:0]                 bc_ff, bc_in;
   logic [15:0]                raddr_ff, raddr_in;
   logic [7:0]                 rtype_ff, rtype_in;
   logic [7:0]                 sum_ff, sum_in;
   logic [15:0]                ext_ff, ext_in;
   logic [20:0]                seg_ff, seg_in;
   logic [32:0]                lin_ff, lin_in;
   logic                       line_bad_ff, line_bad_in;
   logic                       end_ff, end_in;
   logic                       halted_ff, halted_in;
   logic                       wa_ff;
   logic [hrp_pkg::ADDR_W-1:0] bsum_ff;
   logic [hrp_pkg::ADDR_W-1:0] abase_ff;

   logic [8:0]  k;
   logic [8:0]  idx;
   logic [7:0]  byte_val;
   logic [9:0]  k_limit;
   logic [9:0]  need;
   logic        data_type;
   logic [20:0] seg_val;
   logic [32:0] lin_val;
   logic        data_load;
   logic        in_record;

   assign take      = cls_valid && slot_free;
   assign k         = dc_ff[9:1];
   assign idx       = 9'(k - 9'd4);
   assign byte_val  = {nib_ff, cls.hex_val};
   assign k_limit   = {2'b00, bc_ff} + 10'd4;
   assign need      = {1'b0, bc_ff, 1'b0} + 10'd10;
   assign data_type = (rtype_ff == hrp_pkg::TYPE_DATA) || (rtype_ff == hrp_pkg::TYPE_DATA32);
   assign seg_val   = wa_ff ? {ext_ff, 5'b0} : {1'b0, ext_ff, 4'b0};
   assign lin_val   = wa_ff ? {ext_ff, 17'b0} : {1'b0, ext_ff, 16'b0};
   assign data_load = res_load && (res.kind == hrp_pkg::KIND_DATA);
   assign in_record = (phase_ff == PH_REC) || (phase_ff == PH_TRAIL);

   always_comb begin
      phase_in    = phase_ff;
      dc_in       = dc_ff;
      nib_in      = nib_ff;
      bc_in       = bc_ff;
      raddr_in    = raddr_ff;
      rtype_in    = rtype_ff;
      sum_in      = sum_ff;
      ext_in      = ext_ff;
      seg_in      = seg_ff;
      lin_in      = lin_ff;
      line_bad_in = line_bad_ff;
      end_in      = end_ff;
      halted_in   = halted_ff;
      res_load    = 1'b0;
      res         = '0;
      if (take && !halted_ff) begin
         case (phase_ff)
            PH_IDLE: begin
               if (cls.is_colon) begin
                  dc_in       = '0;
                  nib_in      = '0;
                  bc_in       = '0;
                  raddr_in    = '0;
                  rtype_in    = '0;
                  sum_in      = '0;
                  ext_in      = '0;
                  line_bad_in = 1'b0;
                  phase_in    = PH_REC;
               end else if (!cls.is_eol) begin
                  phase_in = PH_SKIP;
               end
            end
            PH_SKIP: begin
               if (cls.is_eol) begin
                  phase_in = PH_IDLE;
               end
            end
            PH_REC, PH_TRAIL: begin
               if (cls.is_eol) begin
                  phase_in = PH_IDLE;
                  if (line_bad_ff) begin
                     res_load = 1'b1;
                     res.kind = hrp_pkg::KIND_DISCARD;
                  end else if (dc_ff > need + 10'd3) begin
                     halted_in = 1'b1;
                     res_load  = 1'b1;
                     res.kind  = hrp_pkg::KIND_FMT_ERR;
                  end else if (dc_ff < need) begin
                     res_load = 1'b1;
                     res.kind = hrp_pkg::KIND_DISCARD;
                  end else if (rtype_ff == hrp_pkg::TYPE_EOF && bc_ff == 8'd0) begin
                     end_in   = 1'b1;
                     res_load = 1'b1;
                     res.kind = hrp_pkg::KIND_END;
                  end else if (rtype_ff == hrp_pkg::TYPE_SEG ||
                               rtype_ff == hrp_pkg::TYPE_LIN) begin
                     res_load = 1'b1;
                     if (bc_ff != 8'd2) begin
                        halted_in = 1'b1;
                        res.kind  = hrp_pkg::KIND_FMT_ERR;
                     end else begin
                        res.kind = hrp_pkg::KIND_BASE;
                        if (rtype_ff == hrp_pkg::TYPE_SEG) begin
                           seg_in = seg_val;
                        end else begin
                           lin_in = lin_val;
                        end
                     end
                  end else if (data_type && bc_ff != 8'd0) begin
                     res_load = 1'b1;
                     if (sum_ff == 8'd0) begin
                        res.kind = hrp_pkg::KIND_REC_OK;
                     end else begin
                        halted_in = 1'b1;
                        res.kind  = hrp_pkg::KIND_CSUM_ERR;
                     end
                  end
               end else if (!cls.is_hex) begin
                  if (cls.is_blank) begin
                     phase_in = PH_TRAIL;
                  end else begin
                     line_bad_in = 1'b1;
                  end
               end else begin
                  if (phase_ff == PH_TRAIL) begin
                     line_bad_in = 1'b1;
                  end
                  if (dc_ff != hrp_pkg::DIGIT_MAX) begin
                     dc_in = dc_ff + 10'd1;
                     if (!dc_ff[0]) begin
                        nib_in = cls.hex_val;
                     end else if ({1'b0, k} <= k_limit) begin
                        sum_in = sum_ff + byte_val;
                        case (k)
                           9'd0: bc_in = byte_val;
                           9'd1: raddr_in[15:8] = byte_val;
                           9'd2: raddr_in[7:0] = byte_val;
                           9'd3: rtype_in = byte_val;
                           9'd4: ext_in[15:8] = byte_val;
                           9'd5: ext_in[7:0] = byte_val;
                           default: sum_in = sum_ff + byte_val;
                        endcase
                        if (k >= 9'd4 && {1'b0, k} < k_limit && !line_bad_in && data_type) begin
                           res_load          = 1'b1;
                           res.kind          = hrp_pkg::KIND_DATA;
                           res.byte_address  = abase_ff + hrp_pkg::ADDR_W'(idx[7:0]);
                           res.data_byte     = byte_val;
                        end
                     end
                  end
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
      res.end_seen = end_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         dc_ff       <= '0;
         nib_ff      <= '0;
         bc_ff       <= '0;
         raddr_ff    <= '0;
         rtype_ff    <= '0;
         sum_ff      <= '0;
         ext_ff      <= '0;
         seg_ff      <= '0;
         lin_ff      <= '0;
         line_bad_ff <= 1'b0;
         end_ff      <= 1'b0;
         halted_ff   <= 1'b0;
         wa_ff       <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         dc_ff       <= dc_in;
         nib_ff      <= nib_in;
         bc_ff       <= bc_in;
         raddr_ff    <= raddr_in;
         rtype_ff    <= rtype_in;
         sum_ff      <= sum_in;
         ext_ff      <= ext_in;
         seg_ff      <= seg_in;
         lin_ff      <= lin_in;
         line_bad_ff <= line_bad_in;
         end_ff      <= end_in;
         halted_ff   <= halted_in;
         if (csr_wr_en) begin
            wa_ff <= csr_wr_data;
         end
      end
   end

   // The address base is registered from the address bytes, and from the bases
   // through the base sum register, so it settles well before the first data byte can follow.
   always_ff @(posedge clock) begin
      bsum_ff  <= hrp_pkg::ADDR_W'(seg_ff) + hrp_pkg::ADDR_W'(lin_ff);
      abase_ff <= bsum_ff + (wa_ff ? hrp_pkg::ADDR_W'({raddr_ff, 1'b0})
                                   : hrp_pkg::ADDR_W'(raddr_ff));
   end

   `HRP_ASSERT_NEXT(a_halt_latches, clock, reset, halted_ff, halted_ff)
   `HRP_ASSERT_IMPLIES(a_halt_quiet, clock, reset, halted_ff, !res_load)
   `HRP_ASSERT_NEXT(a_end_sticky, clock, reset, end_ff, end_ff)
   `HRP_ASSERT_IMPLIES(a_data_in_record, clock, reset, data_load, in_record)

endmodule

/* rtl/hrp_rsp_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex record parser result stage
// Output register that holds a result beat until the sink takes it.
// ----------------------------------------------------------------------------
module hrp_rsp_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                res_load,
   input  hrp_pkg::result_type res,
   output logic                slot_free,
   hrp_rsp_if.source           rsp
);

   logic                valid_ff, valid_in;
   hrp_pkg::result_type res_ff;

   assign slot_free        = !valid_ff || rsp.ready;
   assign valid_in         = res_load || (valid_ff && !rsp.ready);
   assign rsp.valid        = valid_ff;
   assign rsp.kind         = res_ff.kind;
   assign rsp.byte_address = res_ff.byte_address;
   assign rsp.data_byte    = res_ff.data_byte;
   assign rsp.end_seen     = res_ff.end_seen;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         res_ff <= res;
      end
   end

endmodule

/* rtl/hex_record_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex record parser unit
// Streaming parser for hex-record text, one character beat in, at most one
// result beat out per character.
//
// Channel   Direction  Handshake        Payload
// req_bus   in         valid / ready    char_in
// rsp_bus   out        valid / ready    kind, byte_address, data_byte, end_seen
// csr       in         csr_wr_en        csr_wr_data (word addressing)
//
// One character beat is taken every cycle when the result side keeps up.
// A result beat passes through the character register and then the result register:
// the character is decoded from its register straight into the result register.
// Reset is synchronous and returns the parser to the start of a line.
// A stalled result holds in its register and stops the character register;
// req_bus.ready falls at once, or after one more beat if that register is empty.
// ----------------------------------------------------------------------------
module hex_record_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   hrp_req_if.sink     req_bus,
   hrp_rsp_if.source   rsp_bus
);

   logic                    cls_valid;
   hrp_pkg::char_class_type cls;
   logic                    take;
   logic                    slot_free;
   logic                    res_load;
   hrp_pkg::result_type     res;

   hrp_char_stage u_char_stage (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .take      (take),
      .cls_valid (cls_valid),
      .cls       (cls)
   );

   hrp_record_core u_record_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cls_valid   (cls_valid),
      .cls         (cls),
      .slot_free   (slot_free),
      .take        (take),
      .res_load    (res_load),
      .res         (res)
   );

   hrp_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .res_load  (res_load),
      .res       (res),
      .slot_free (slot_free),
      .rsp       (rsp_bus)
   );

endmodule
